@@ rtl/spim_pkg.sv @@
`timescale 1ns / 1ps

package spim_pkg;

    localparam int MAX_DIVIDER = 128;
    localparam int PRESCALE_W  = 7;
    localparam int EDGE_W      = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 3;

    localparam logic [PRESCALE_W-1:0] MAX_HALF = PRESCALE_W'(MAX_DIVIDER / 2);
    localparam logic [EDGE_W-1:0]     LAST_EDGE = EDGE_W'(16);

    localparam logic [1:0] CMD_WRITE_DATA  = 2'd0;
    localparam logic [1:0] CMD_READ_DATA   = 2'd1;
    localparam logic [1:0] CMD_READ_STATUS = 2'd2;
    localparam logic [1:0] CMD_TICK        = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LSB_FIRST  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CPOL       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CPHA       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_IRQ_ENABLE = 3'd5;

    typedef struct packed {
        logic       sck;
        logic       mosi;
        logic [7:0] read_data;
        logic       transfer_done;
        logic       busy_res;
        logic       interrupt_request;
    } result_t;

    // half of the SCK period in ticks for each rate code
    function automatic logic [PRESCALE_W-1:0] half_period(input logic [2:0] code);
        logic [PRESCALE_W-1:0] half;
        unique case (code)
            3'd0:    half = PRESCALE_W'(2);
            3'd1:    half = PRESCALE_W'(8);
            3'd2:    half = PRESCALE_W'(32);
            3'd4:    half = PRESCALE_W'(1);
            3'd5:    half = PRESCALE_W'(4);
            3'd6:    half = PRESCALE_W'(16);
            default: half = MAX_HALF;
        endcase
        return half;
    endfunction

endpackage

@@ rtl/spim_core.sv @@
`timescale 1ns / 1ps

module spim_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [spim_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_accept,
    input  logic [1:0]                      in_command,
    input  logic [7:0]                      in_write_data,
    input  logic                            in_miso,
    output spim_pkg::result_t               result
);
    import spim_pkg::*;

    logic                  enable_reg, enable_next;
    logic                  lsb_first_reg, lsb_first_next;
    logic                  cpol_reg, cpol_next;
    logic                  cpha_reg, cpha_next;
    logic [2:0]            rate_reg, rate_next;
    logic                  irq_en_reg, irq_en_next;

    logic [7:0]            shift_reg, shift_next;
    logic [7:0]            received_reg, received_next;
    logic [EDGE_W-1:0]     edge_count_reg, edge_count_next;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic                  sck_level_reg, sck_level_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  mosi_reg, mosi_next;

    logic [7:0]            read_data;
    logic [EDGE_W-1:0]     edge_inc;
    logic [PRESCALE_W-1:0] prescale_inc;
    logic                  leading;

    assign edge_inc     = edge_count_reg + EDGE_W'(1);
    assign prescale_inc = prescale_reg + PRESCALE_W'(1);
    assign leading      = edge_inc[0];

    always_comb begin
        enable_next     = enable_reg;
        lsb_first_next  = lsb_first_reg;
        cpol_next       = cpol_reg;
        cpha_next       = cpha_reg;
        rate_next       = rate_reg;
        irq_en_next     = irq_en_reg;
        shift_next      = shift_reg;
        received_next   = received_reg;
        edge_count_next = edge_count_reg;
        prescale_next   = prescale_reg;
        sck_level_next  = sck_level_reg;
        busy_next       = busy_reg;
        done_next       = done_reg;
        mosi_next       = mosi_reg;
        read_data       = 8'd0;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_ENABLE: begin
                    enable_next = cfg_data[0];
                    if (!cfg_data[0] && busy_reg) begin
                        busy_next       = 1'b0;
                        edge_count_next = '0;
                        prescale_next   = '0;
                        sck_level_next  = cpol_reg;
                    end
                end
                REG_LSB_FIRST: lsb_first_next = cfg_data[0];
                REG_CPOL: begin
                    cpol_next = cfg_data[0];
                    if (!busy_reg) begin
                        sck_level_next = cfg_data[0];
                    end
                end
                REG_CPHA:       cpha_next   = cfg_data[0];
                REG_RATE:       rate_next   = cfg_data;
                REG_IRQ_ENABLE: irq_en_next = cfg_data[0];
                default: ;
            endcase
        end else if (in_accept) begin
            unique case (in_command)
                CMD_WRITE_DATA: begin
                    if (!busy_reg && enable_reg) begin
                        shift_next      = in_write_data;
                        busy_next       = 1'b1;
                        edge_count_next = '0;
                        prescale_next   = '0;
                        sck_level_next  = cpol_reg;
                        if (!cpha_reg) begin
                            mosi_next = lsb_first_reg ? in_write_data[0] : in_write_data[7];
                        end
                    end
                end
                CMD_READ_DATA: begin
                    read_data = received_reg;
                    done_next = 1'b0;
                end
                CMD_READ_STATUS: ;
                CMD_TICK: begin
                    if (busy_reg) begin
                        if (prescale_inc >= half_period(rate_reg)) begin
                            prescale_next   = '0;
                            edge_count_next = edge_inc;
                            sck_level_next  = ~sck_level_reg;
                            if (leading != cpha_reg) begin
                                shift_next = lsb_first_reg ? {in_miso, shift_reg[7:1]}
                                                           : {shift_reg[6:0], in_miso};
                            end else if (cpha_reg || edge_inc < LAST_EDGE) begin
                                mosi_next = lsb_first_reg ? shift_reg[0] : shift_reg[7];
                            end
                            if (edge_inc >= LAST_EDGE) begin
                                received_next   = shift_next;
                                busy_next       = 1'b0;
                                done_next       = 1'b1;
                                edge_count_next = '0;
                                sck_level_next  = cpol_reg;
                            end
                        end else begin
                            prescale_next = prescale_inc;
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        result.sck               = busy_next ? sck_level_next : cpol_reg;
        result.mosi              = mosi_next;
        result.read_data         = read_data;
        result.transfer_done     = done_next;
        result.busy_res          = busy_next;
        result.interrupt_request = done_next & irq_en_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            lsb_first_reg  <= 1'b0;
            cpol_reg       <= 1'b0;
            cpha_reg       <= 1'b0;
            rate_reg       <= 3'd0;
            irq_en_reg     <= 1'b0;
            shift_reg      <= 8'd0;
            received_reg   <= 8'd0;
            edge_count_reg <= '0;
            prescale_reg   <= '0;
            sck_level_reg  <= 1'b0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            mosi_reg       <= 1'b0;
        end else begin
            enable_reg     <= enable_next;
            lsb_first_reg  <= lsb_first_next;
            cpol_reg       <= cpol_next;
            cpha_reg       <= cpha_next;
            rate_reg       <= rate_next;
            irq_en_reg     <= irq_en_next;
            shift_reg      <= shift_next;
            received_reg   <= received_next;
            edge_count_reg <= edge_count_next;
            prescale_reg   <= prescale_next;
            sck_level_reg  <= sck_level_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            mosi_reg       <= mosi_next;
        end
    end

endmodule

@@ rtl/spim_out_buf.sv @@
`timescale 1ns / 1ps

module spim_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  spim_pkg::result_t push_data,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output spim_pkg::result_t out_data
);
    import spim_pkg::*;

    result_t    entry_mem [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic       pop;

    assign has_room  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign out_data  = entry_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

@@ rtl/spi_master_byte_transceiver.sv @@
`timescale 1ns / 1ps
// Byte-wide SPI master (modes 0 to 3) driven by a word stream.
// Input channel (s_valid/s_ready): each word carries a command: write data
// (start a transfer), read data (return the received byte, clear done),
// read status, or clock tick (one prescaler step; samples s_miso).
// Result channel (m_valid/m_ready): exactly one word per input word, with
// SCK and MOSI levels, read data, done, busy and interrupt request as they
// stand after that command.
// Configuration: cfg_wr_en/cfg_index/cfg_data write one of the six control
// registers per write; write only while no result is outstanding.
// Result path: a result is registered in the two-entry result buffer when its input word is taken.
// Throughput: one word per cycle while s_ready is high; the state update is a single pass of
// logic between the state registers and the two-entry result buffer.
// Stall: while the receiver holds m_ready low, up to two results queue;
// s_ready then drops until one is taken. No word is lost or repeated.
// Reset: all control and shift state clears, SCK idles low, MOSI is low.

module spi_master_byte_transceiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [spim_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [spim_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_command,
    input  logic [7:0]                       s_write_data,
    input  logic                             s_miso,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_sck,
    output logic                             m_mosi,
    output logic [7:0]                       m_read_data,
    output logic                             m_transfer_done,
    output logic                             m_busy_res,
    output logic                             m_interrupt_request
);
    import spim_pkg::*;

    logic    in_accept;
    result_t core_result;
    result_t out_result;

    assign in_accept = s_valid && s_ready;

    spim_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .in_command    (s_command),
        .in_write_data (s_write_data),
        .in_miso       (s_miso),
        .result        (core_result)
    );

    spim_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_accept),
        .push_data (core_result),
        .has_room  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_sck               = out_result.sck;
    assign m_mosi              = out_result.mosi;
    assign m_read_data         = out_result.read_data;
    assign m_transfer_done     = out_result.transfer_done;
    assign m_busy_res          = out_result.busy_res;
    assign m_interrupt_request = out_result.interrupt_request;

endmodule

@@ sim/tb_spi_master_byte_transceiver.sv @@
`timescale 1ns / 1ps

module tb_spi_master_byte_transceiver;
    import spim_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 1150;

    localparam int DIVIDER_OF [8] = '{4, 16, 64, MAX_DIVIDER, 2, 8, 32, MAX_DIVIDER};
    localparam logic [2:0] RATE_PICKS [16] = '{4, 4, 4, 4, 4, 0, 0, 0, 0, 5, 5, 1, 6, 2, 3, 7};

    localparam result_t NO_RES   = '0;
    localparam result_t START_FF = '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0};

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  val;
        logic [1:0]             cmd;
        logic [7:0]             wd;
        logic                   mi;
        logic [7:0]             reps;
        logic                   typed;
        result_t                want;
    } plan_row_t;

    localparam int PLAN_LEN = 28;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_STATUS, 8'h00, 1'b0, 8'd1,  1'b1, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_WRITE_DATA,  8'hFF, 1'b1, 8'd1,  1'b1, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b1, 8'd1,  1'b1, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_DATA,   8'hFF, 1'b0, 8'd1,  1'b1, NO_RES},
        '{1'b1, REG_ENABLE,     3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_RATE,       3'd4, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_IRQ_ENABLE, 3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_WRITE_DATA,  8'hFF, 1'b0, 8'd1,  1'b1, START_FF},
        '{1'b0, REG_ENABLE,     3'd0, CMD_WRITE_DATA,  8'h00, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b1, 8'd16, 1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_STATUS, 8'h00, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b1, REG_LSB_FIRST,  3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_CPOL,       3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_CPHA,       3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_RATE,       3'd7, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_WRITE_DATA,  8'h01, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b1, 8'd3,  1'b0, NO_RES},
        '{1'b1, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_STATUS, 8'h00, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b1, REG_ENABLE,     3'd1, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b1, REG_RATE,       3'd6, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_WRITE_DATA,  8'h80, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b0, 8'd10, 1'b0, NO_RES},
        '{1'b1, REG_RATE,       3'd4, CMD_TICK,        8'h00, 1'b0, 8'd0,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b1, 8'd1,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_DATA,   8'h00, 1'b0, 8'd1,  1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_TICK,        8'h00, 1'b1, 8'd16, 1'b0, NO_RES},
        '{1'b0, REG_ENABLE,     3'd0, CMD_READ_DATA,   8'h00, 1'b0, 8'd1,  1'b0, NO_RES}
    };

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [1:0] s_command;
    logic [7:0] s_write_data;
    logic s_miso;
    logic m_valid;
    logic m_ready;
    logic m_sck;
    logic m_mosi;
    logic [7:0] m_read_data;
    logic m_transfer_done;
    logic m_busy_res;
    logic m_interrupt_request;

    // shadow of the transceiver
    logic [7:0] sh_reg, rx_byte;
    logic [EDGE_W-1:0] edge_cnt;
    logic [PRESCALE_W-1:0] presc_cnt;
    logic sck_lvl, busy, done, mosi_lvl;
    logic en, lsb, cpol, cpha, ie;
    logic [2:0] rate;

    result_t bus_status_q [$];
    result_t head;
    logic steady;
    int n_err = 0;
    int n_items = 0;
    int n_results = 0;
    int n_bytes = 0;
    int n_aborts = 0;
    int cycles = 0;

    spi_master_byte_transceiver dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_command          (s_command),
        .s_write_data       (s_write_data),
        .s_miso             (s_miso),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sck              (m_sck),
        .m_mosi             (m_mosi),
        .m_read_data        (m_read_data),
        .m_transfer_done    (m_transfer_done),
        .m_busy_res         (m_busy_res),
        .m_interrupt_request(m_interrupt_request)
    );

    always #4 aclk = ~aclk;

    function automatic result_t advance_spi(input logic [1:0] cmd, input logic [7:0] wd,
                                            input logic mi);
        result_t r;
        logic [PRESCALE_W-1:0] half;
        r = '0;
        case (cmd)
            CMD_WRITE_DATA: if (!busy && en) begin
                sh_reg = wd;
                busy = 1'b1;
                edge_cnt = '0;
                presc_cnt = '0;
                sck_lvl = cpol;
                if (!cpha)
                    mosi_lvl = lsb ? wd[0] : wd[7];
            end
            CMD_READ_DATA: begin
                r.read_data = rx_byte;
                done = 1'b0;
            end
            CMD_TICK: if (busy) begin
                half = PRESCALE_W'(DIVIDER_OF[rate] / 2);
                presc_cnt = presc_cnt + 1'b1;
                if (presc_cnt >= half) begin
                    presc_cnt = '0;
                    edge_cnt = edge_cnt + 1'b1;
                    sck_lvl = ~sck_lvl;
                    // odd edges lead; sample on the edge picked by phase, drive on the other
                    if (edge_cnt[0] != cpha)
                        sh_reg = lsb ? {mi, sh_reg[7:1]} : {sh_reg[6:0], mi};
                    else if (cpha || edge_cnt < LAST_EDGE)
                        mosi_lvl = lsb ? sh_reg[0] : sh_reg[7];
                    if (edge_cnt >= LAST_EDGE) begin
                        rx_byte = sh_reg;
                        busy = 1'b0;
                        done = 1'b1;
                        edge_cnt = '0;
                        presc_cnt = '0;
                        sck_lvl = cpol;
                        n_bytes++;
                    end
                end
            end
            default: ;
        endcase
        r.sck = busy ? sck_lvl : cpol;
        r.mosi = mosi_lvl;
        r.transfer_done = done;
        r.busy_res = busy;
        r.interrupt_request = done & ie;
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        while (bus_status_q.size() != 0)
            @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            REG_ENABLE: begin
                en = val[0];
                if (!en && busy) begin
                    busy = 1'b0;
                    edge_cnt = '0;
                    presc_cnt = '0;
                    sck_lvl = cpol;
                    n_aborts++;
                end
            end
            REG_LSB_FIRST: lsb = val[0];
            REG_CPOL: begin
                cpol = val[0];
                if (!busy)
                    sck_lvl = cpol;
            end
            REG_CPHA: cpha = val[0];
            REG_RATE: rate = val;
            REG_IRQ_ENABLE: ie = val[0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] wd, input logic mi,
                             input logic typed, input result_t want);
        result_t r;
        int pick;
        s_valid <= 1'b1;
        s_command <= cmd;
        s_write_data <= wd;
        s_miso <= mi;
        do
            @(posedge aclk);
        while (!s_ready);
        r = advance_spi(cmd, wd, mi);
        bus_status_q.push_back(typed ? want : r);
        n_items++;
        pick = $urandom_range(0, 99);
        if (!steady && pick >= 65) begin
            s_valid <= 1'b0;
            repeat (pick < 93 ? $urandom_range(1, 3) : $urandom_range(8, 40))
                @(posedge aclk);
        end
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            n_err++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (bus_status_q.size() == 0) begin
                n_err++;
                $display("%0t: result word with nothing pending, expected none got sck=%0d",
                         $time, m_sck);
            end else begin
                head = bus_status_q.pop_front();
                compare_field("sck", head.sck, m_sck);
                compare_field("mosi", head.mosi, m_mosi);
                compare_field("read_data", head.read_data, m_read_data);
                compare_field("transfer_done", head.transfer_done, m_transfer_done);
                compare_field("busy", head.busy_res, m_busy_res);
                compare_field("interrupt_request", head.interrupt_request,
                              m_interrupt_request);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending",
                     cycles, bus_status_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : sink
        bit held;
        int pick;
        held = 1'b0;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            pick = $urandom_range(0, 99);
            if (!held && n_results >= 400 && s_valid) begin
                // hold off long enough to back up the input side
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else if (pick < 55) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end else if (pick < 90) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(8, 40)) @(posedge aclk);
            end
        end
    end

    initial begin
        int batch;
        int pick;
        int random_start;
        logic [1:0] cmd;
        logic [CFG_DATA_W-1:0] v;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data = '0;
        s_valid = 1'b0;
        s_command = CMD_READ_STATUS;
        s_write_data = 8'h00;
        s_miso = 1'b0;
        steady = 1'b0;
        sh_reg = 8'h00;
        rx_byte = 8'h00;
        edge_cnt = '0;
        presc_cnt = '0;
        sck_lvl = 1'b0;
        busy = 1'b0;
        done = 1'b0;
        mosi_lvl = 1'b0;
        en = 1'b0;
        lsb = 1'b0;
        cpol = 1'b0;
        cpha = 1'b0;
        ie = 1'b0;
        rate = 3'd0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg)
                write_reg(PLAN[i].idx, PLAN[i].val);
            else
                repeat (PLAN[i].reps)
                    send_word(PLAN[i].cmd, PLAN[i].wd, PLAN[i].mi, PLAN[i].typed, PLAN[i].want);
        end

        random_start = n_items;
        while (n_items - random_start < RANDOM_WORDS) begin
            if ($urandom_range(0, 99) < 30) begin
                v = CFG_DATA_W'($urandom_range(0, 7));
                v[0] = ($urandom_range(0, 99) < 85);
                write_reg(REG_ENABLE, v);
            end
            if ($urandom_range(0, 99) < 40)
                write_reg(REG_LSB_FIRST, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 40)
                write_reg(REG_CPOL, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 40)
                write_reg(REG_CPHA, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 50)
                write_reg(REG_RATE, RATE_PICKS[$urandom_range(0, 15)]);
            if ($urandom_range(0, 99) < 30)
                write_reg(REG_IRQ_ENABLE, CFG_DATA_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 99) < 5)
                write_reg(CFG_INDEX_W'($urandom_range(6, 7)), CFG_DATA_W'($urandom_range(0, 7)));
            // keep the block enabled most of the time so transfers run
            if (!en && $urandom_range(0, 99) < 70)
                write_reg(REG_ENABLE, 3'd1);

            batch = $urandom_range(20, 80);
            steady = ($urandom_range(0, 3) == 0);
            repeat (batch) begin
                pick = $urandom_range(0, 99);
                if (!busy)
                    cmd = pick < 45 ? CMD_WRITE_DATA : pick < 85 ? CMD_TICK :
                          pick < 93 ? CMD_READ_DATA : CMD_READ_STATUS;
                else
                    cmd = pick < 80 ? CMD_TICK : pick < 90 ? CMD_READ_DATA :
                          pick < 95 ? CMD_READ_STATUS : CMD_WRITE_DATA;
                send_word(cmd, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                          NO_RES);
            end
        end

        s_valid <= 1'b0;
        while (bus_status_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d words across all modes and rates, %0d results checked",
                 n_items, n_results);
        $display("%0d bytes completed, %0d transfers cut short by disable, %0d mismatches",
                 n_bytes, n_aborts, n_err);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ spi_master_byte_transceiver.f @@
rtl/spim_pkg.sv
rtl/spim_core.sv
rtl/spim_out_buf.sv
rtl/spi_master_byte_transceiver.sv
sim/tb_spi_master_byte_transceiver.sv
